// File: hdl/codepage_transcoder_assert.svh
// Assertion macros for the code page transcoder.
`ifndef CODEPAGE_TRANSCODER_ASSERT_SVH
`define CODEPAGE_TRANSCODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CPT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/cpt_pkg.sv
// Package: code page tables, codes and conversion functions for the transcoder.
package cpt_pkg;

    localparam int CU_W      = 16;
    localparam int PAGE_W    = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 2;

    localparam logic [PAGE_W-1:0]    CP_LATIN1 = 2'd0;
    localparam logic [PAGE_W-1:0]    CP_1252   = 2'd1;
    localparam logic [PAGE_W-1:0]    CP_1250   = 2'd2;

    localparam logic                 DIR_ENCODE = 1'b0;
    localparam logic                 DIR_DECODE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_CODEPAGE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 1'd1;

    localparam logic [CU_W-1:0] REPL_CHAR = 16'hFFFD;
    localparam logic [CU_W-1:0] QMARK     = 16'h003F;

    localparam logic [CU_W-1:0] CP1252_HI [32] = '{
        16'h20AC, 16'hFFFD, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'hFFFD, 16'h017D, 16'hFFFD,
        16'hFFFD, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'hFFFD, 16'h017E, 16'h0178
    };

    localparam logic [CU_W-1:0] CP1250_C1 [32] = '{
        16'h20AC, 16'hFFFD, 16'h201A, 16'hFFFD, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'hFFFD, 16'h2030, 16'h0160, 16'h2039, 16'h015A, 16'h0164, 16'h017D, 16'h0179,
        16'hFFFD, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'hFFFD, 16'h2122, 16'h0161, 16'h203A, 16'h015B, 16'h0165, 16'h017E, 16'h017A
    };

    localparam logic [CU_W-1:0] CP1250_G1 [96] = '{
        16'h00A0, 16'h02C7, 16'h02D8, 16'h0141, 16'h00A4, 16'h0104, 16'h00A6, 16'h00A7,
        16'h00A8, 16'h00A9, 16'h015E, 16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h017B,
        16'h00B0, 16'h00B1, 16'h02DB, 16'h0142, 16'h00B4, 16'h00B5, 16'h00B6, 16'h00B7,
        16'h00B8, 16'h0105, 16'h015F, 16'h00BB, 16'h013D, 16'h02DD, 16'h013E, 16'h017C,
        16'h0154, 16'h00C1, 16'h00C2, 16'h0102, 16'h00C4, 16'h0139, 16'h0106, 16'h00C7,
        16'h010C, 16'h00C9, 16'h0118, 16'h00CB, 16'h011A, 16'h00CD, 16'h00CE, 16'h010E,
        16'h0110, 16'h0143, 16'h0147, 16'h00D3, 16'h00D4, 16'h0150, 16'h00D6, 16'h00D7,
        16'h0158, 16'h016E, 16'h00DA, 16'h0170, 16'h00DC, 16'h00DD, 16'h0162, 16'h00DF,
        16'h0155, 16'h00E1, 16'h00E2, 16'h0103, 16'h00E4, 16'h013A, 16'h0107, 16'h00E7,
        16'h010D, 16'h00E9, 16'h0119, 16'h00EB, 16'h011B, 16'h00ED, 16'h00EE, 16'h010F,
        16'h0111, 16'h0144, 16'h0148, 16'h00F3, 16'h00F4, 16'h0151, 16'h00F6, 16'h00F7,
        16'h0159, 16'h016F, 16'h00FA, 16'h0171, 16'h00FC, 16'h00FD, 16'h0163, 16'h02D9
    };

    typedef struct packed {
        logic [CU_W-1:0] value;
        logic            miss;
    } t_conv;

    function automatic t_conv f_encode(input logic [CU_W-1:0] cp,
                                       input logic [PAGE_W-1:0] page);
        t_conv      r;
        logic       hit_c1;
        logic       hit_g1;
        logic [4:0] k_c1;
        logic [6:0] k_g1;
        r.value = cp;
        r.miss  = 1'b0;
        hit_c1  = 1'b0;
        hit_g1  = 1'b0;
        k_c1    = '0;
        k_g1    = '0;
        case (page)
            CP_1252: begin
                if (!(cp inside {[16'h0000:16'h007F], [16'h00A0:16'h00FF]})) begin
                    for (int i = 31; i >= 0; i--) begin
                        if (CP1252_HI[i] == cp) begin
                            hit_c1 = 1'b1;
                            k_c1   = 5'(i);
                        end
                    end
                    if (hit_c1) begin
                        r.value = {11'd0, k_c1} + 16'h0080;
                    end else begin
                        r.value = QMARK;
                        r.miss  = 1'b1;
                    end
                end
            end
            CP_1250: begin
                if (!(cp inside {[16'h0000:16'h007F]})) begin
                    for (int i = 31; i >= 0; i--) begin
                        if (CP1250_C1[i] == cp) begin
                            hit_c1 = 1'b1;
                            k_c1   = 5'(i);
                        end
                    end
                    for (int j = 95; j >= 0; j--) begin
                        if (CP1250_G1[j] == cp) begin
                            hit_g1 = 1'b1;
                            k_g1   = 7'(j);
                        end
                    end
                    if (hit_c1) begin
                        r.value = {11'd0, k_c1} + 16'h0080;
                    end else if (hit_g1) begin
                        r.value = {9'd0, k_g1} + 16'h00A0;
                    end else begin
                        r.value = QMARK;
                        r.miss  = 1'b1;
                    end
                end
            end
            default: begin
                if (cp > 16'h00FF) begin
                    r.value = QMARK;
                    r.miss  = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    function automatic t_conv f_decode(input logic [7:0] b,
                                       input logic [PAGE_W-1:0] page);
        t_conv      r;
        logic [7:0] off;
        off     = b - 8'hA0;
        r.value = {8'd0, b};
        case (page)
            CP_1252: begin
                if (b inside {[8'h80:8'h9F]}) begin
                    r.value = CP1252_HI[b[4:0]];
                end
            end
            CP_1250: begin
                if (b inside {[8'h80:8'h9F]}) begin
                    r.value = CP1250_C1[b[4:0]];
                end else if (b >= 8'hA0) begin
                    r.value = CP1250_G1[off[6:0]];
                end
            end
            default: begin
                r.value = {8'd0, b};
            end
        endcase
        r.miss = (r.value == REPL_CHAR);
        return r;
    endfunction

endpackage

// File: hdl/codepage_transcoder.sv
// Top level: single-byte code page transcoder, UTF-16 code unit <-> byte.
//
// channel  | valid   | stall   | payload
// ---------+---------+---------+------------------------------------------
// input    | i_valid | o_stall | i_code_unit, i_last
// output   | o_valid | i_stall | o_value, o_unmapped, o_lossy, o_last_out
// config   | i_cfg_we| -       | i_cfg_index, i_cfg_data
//
// One character per cycle sustained while i_stall is low (input register, table
// lookup, result register). Table lookup is a constant compare tree.
// Reset is synchronous, active low; clears valids, config registers and lossy flag.
// Output stall backs up through the input register to o_stall.
module codepage_transcoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cpt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cpt_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [cpt_pkg::CU_W-1:0]       i_code_unit,
    input  logic                           i_last,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [cpt_pkg::CU_W-1:0]       o_value,
    output logic                           o_unmapped,
    output logic                           o_lossy,
    output logic                           o_last_out
);
    import cpt_pkg::*;

    logic [PAGE_W-1:0] r_codepage;
    logic              r_direction;
    logic              r_lossy_seen;

    logic              r_s1_valid;
    logic [CU_W-1:0]   r_s1_cu;
    logic              r_s1_last;

    logic              r_out_valid;
    logic [CU_W-1:0]   r_out_value;
    logic              r_out_unmapped;
    logic              r_out_lossy;
    logic              r_out_last;

    logic              out_free;
    logic              s1_move;
    logic              in_ready;
    logic              in_take;
    t_conv             conv;
    logic              n_lossy;

    assign out_free = !r_out_valid || !i_stall;
    assign s1_move  = r_s1_valid && out_free;
    assign in_ready = !r_s1_valid || s1_move;
    assign in_take  = i_valid && in_ready;

    always_comb begin
        if (r_direction == DIR_DECODE) begin
            conv = f_decode(r_s1_cu[7:0], r_codepage);
        end else begin
            conv = f_encode(r_s1_cu, r_codepage);
        end
        n_lossy = r_lossy_seen | conv.miss;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codepage  <= CP_LATIN1;
            r_direction <= DIR_ENCODE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CODEPAGE:  r_codepage  <= i_cfg_data[PAGE_W-1:0];
                REG_DIRECTION: r_direction <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_lossy_seen <= 1'b0;
        end else begin
            if (in_ready) begin
                r_s1_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
            if (s1_move) begin
                r_lossy_seen <= r_s1_last ? 1'b0 : n_lossy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_cu   <= i_code_unit;
            r_s1_last <= i_last;
        end
        if (s1_move) begin
            r_out_value    <= conv.value;
            r_out_unmapped <= conv.miss;
            r_out_lossy    <= n_lossy;
            r_out_last     <= r_s1_last;
        end
    end

    assign o_stall    = !in_ready;
    assign o_valid    = r_out_valid;
    assign o_value    = r_out_value;
    assign o_unmapped = r_out_unmapped;
    assign o_lossy    = r_out_lossy;
    assign o_last_out = r_out_last;

`include "codepage_transcoder_assert.svh"

    `CPT_ASSERT_NOW(a_unmapped_lossy, r_out_valid && r_out_unmapped, r_out_lossy,
                    "unmapped without lossy")
    `CPT_ASSERT_NOW(a_decode_repl, s1_move && r_direction == DIR_DECODE && conv.miss,
                    conv.value == REPL_CHAR, "decode miss not U+FFFD")
    `CPT_ASSERT_NOW(a_encode_qmark, s1_move && r_direction == DIR_ENCODE && conv.miss,
                    conv.value == QMARK, "encode miss not question mark")
    `CPT_ASSERT_NEXT(a_last_clears, s1_move && r_s1_last, !r_lossy_seen,
                     "lossy not cleared after last")
    `CPT_ASSERT_NOW(a_full_stall, r_s1_valid && r_out_valid && i_stall, o_stall,
                    "full pipe not stalling input")

endmodule

// File: test/tb_top.sv
// Testbench for codepage_transcoder: random and directed characters checked by a scoreboard.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import cpt_pkg::*;

    localparam logic [PAGE_W-1:0] CP_UNUSED  = 2'd3;
    localparam int                HOLD_LEN   = 300;
    localparam int                IDLE_LIMIT = 3000;
    localparam int                DRAIN_WAIT = 4;
    localparam int                N_PHASES   = 16;
    localparam int                PHASE_LEN  = 125;

    localparam logic [CU_W-1:0] T1252_C1 [32] = '{
        16'h20AC, 16'hFFFD, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'hFFFD, 16'h017D, 16'hFFFD,
        16'hFFFD, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'hFFFD, 16'h017E, 16'h0178
    };

    localparam logic [CU_W-1:0] T1250_C1 [32] = '{
        16'h20AC, 16'hFFFD, 16'h201A, 16'hFFFD, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'hFFFD, 16'h2030, 16'h0160, 16'h2039, 16'h015A, 16'h0164, 16'h017D, 16'h0179,
        16'hFFFD, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'hFFFD, 16'h2122, 16'h0161, 16'h203A, 16'h015B, 16'h0165, 16'h017E, 16'h017A
    };

    localparam logic [CU_W-1:0] T1250_G1 [96] = '{
        16'h00A0, 16'h02C7, 16'h02D8, 16'h0141, 16'h00A4, 16'h0104, 16'h00A6, 16'h00A7,
        16'h00A8, 16'h00A9, 16'h015E, 16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h017B,
        16'h00B0, 16'h00B1, 16'h02DB, 16'h0142, 16'h00B4, 16'h00B5, 16'h00B6, 16'h00B7,
        16'h00B8, 16'h0105, 16'h015F, 16'h00BB, 16'h013D, 16'h02DD, 16'h013E, 16'h017C,
        16'h0154, 16'h00C1, 16'h00C2, 16'h0102, 16'h00C4, 16'h0139, 16'h0106, 16'h00C7,
        16'h010C, 16'h00C9, 16'h0118, 16'h00CB, 16'h011A, 16'h00CD, 16'h00CE, 16'h010E,
        16'h0110, 16'h0143, 16'h0147, 16'h00D3, 16'h00D4, 16'h0150, 16'h00D6, 16'h00D7,
        16'h0158, 16'h016E, 16'h00DA, 16'h0170, 16'h00DC, 16'h00DD, 16'h0162, 16'h00DF,
        16'h0155, 16'h00E1, 16'h00E2, 16'h0103, 16'h00E4, 16'h013A, 16'h0107, 16'h00E7,
        16'h010D, 16'h00E9, 16'h0119, 16'h00EB, 16'h011B, 16'h00ED, 16'h00EE, 16'h010F,
        16'h0111, 16'h0144, 16'h0148, 16'h00F3, 16'h00F4, 16'h0151, 16'h00F6, 16'h00F7,
        16'h0159, 16'h016F, 16'h00FA, 16'h0171, 16'h00FC, 16'h00FD, 16'h0163, 16'h02D9
    };

    typedef struct {
        logic [CU_W-1:0] value;
        logic            unmapped;
        logic            lossy;
        logic            last;
    } t_char_result;

    class t_char_scoreboard;
        logic [PAGE_W-1:0] page;
        logic              dir;
        logic              lossy_seen;
        t_char_result      pending_q[$];
        int                mismatches;

        function new();
            page       = CP_LATIN1;
            dir        = DIR_ENCODE;
            lossy_seen = 1'b0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
            if (idx == REG_CODEPAGE) begin
                page = d;
            end else if (idx == REG_DIRECTION) begin
                dir = d[0];
            end
        endfunction

        // {miss, value}
        function logic [CU_W:0] encode_cp(logic [CU_W-1:0] cp);
            logic hit;
            int   k;
            hit = 1'b0;
            k   = 0;
            if (page == CP_1252) begin
                if (cp < 16'h0080 || (cp >= 16'h00A0 && cp <= 16'h00FF)) begin
                    return {1'b0, cp};
                end
                for (int i = 0; i < 32; i++) begin
                    if (!hit && T1252_C1[i] == cp) begin
                        hit = 1'b1;
                        k   = i;
                    end
                end
                if (hit) begin
                    return {1'b0, 16'(16'h0080 + k)};
                end
            end else if (page == CP_1250) begin
                if (cp < 16'h0080) begin
                    return {1'b0, cp};
                end
                for (int i = 0; i < 32; i++) begin
                    if (!hit && T1250_C1[i] == cp) begin
                        hit = 1'b1;
                        k   = i;
                    end
                end
                if (hit) begin
                    return {1'b0, 16'(16'h0080 + k)};
                end
                for (int i = 0; i < 96; i++) begin
                    if (!hit && T1250_G1[i] == cp) begin
                        hit = 1'b1;
                        k   = i;
                    end
                end
                if (hit) begin
                    return {1'b0, 16'(16'h00A0 + k)};
                end
            end else begin
                if (cp <= 16'h00FF) begin
                    return {1'b0, cp};
                end
            end
            return {1'b1, QMARK};
        endfunction

        function logic [CU_W:0] decode_byte(logic [7:0] b);
            logic [CU_W-1:0] u;
            logic [7:0]      off;
            u   = {8'h00, b};
            off = b - 8'hA0;
            if (page == CP_1252) begin
                if (b >= 8'h80 && b < 8'hA0) begin
                    u = T1252_C1[b[4:0]];
                end
            end else if (page == CP_1250) begin
                if (b >= 8'h80 && b < 8'hA0) begin
                    u = T1250_C1[b[4:0]];
                end else if (b >= 8'hA0) begin
                    u = T1250_G1[off[6:0]];
                end
            end
            return {(u == REPL_CHAR), u};
        endfunction

        function void note_char(logic [CU_W-1:0] cu, logic last);
            logic [CU_W:0] conv;
            t_char_result  r;
            if (dir == DIR_ENCODE) begin
                conv = encode_cp(cu);
            end else begin
                conv = decode_byte(cu[7:0]);
            end
            r.value    = conv[CU_W-1:0];
            r.unmapped = conv[CU_W];
            r.lossy    = lossy_seen | conv[CU_W];
            r.last     = last;
            lossy_seen = last ? 1'b0 : r.lossy;
            pending_q.push_back(r);
        endfunction

        function void check_char(logic [CU_W-1:0] value, logic unmapped, logic lossy,
                                 logic last);
            t_char_result e;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: value=%h unmapped=%b lossy=%b last=%b",
                             value, unmapped, lossy, last);
                end
                return;
            end
            e = pending_q.pop_front();
            if (value !== e.value || unmapped !== e.unmapped || lossy !== e.lossy
                    || last !== e.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    // value/unmapped/lossy/last
                    $display("mismatch: exp %h/%b/%b/%b got %h/%b/%b/%b",
                             e.value, e.unmapped, e.lossy, e.last,
                             value, unmapped, lossy, last);
                end
            end
        endfunction

        function int pending();
            return pending_q.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;
    logic                 i_valid;
    logic                 o_stall;
    logic [CU_W-1:0]      i_code_unit;
    logic                 i_last;
    logic                 o_valid;
    logic                 i_stall;
    logic [CU_W-1:0]      o_value;
    logic                 o_unmapped;
    logic                 o_lossy;
    logic                 o_last_out;

    t_char_scoreboard sb = new();
    bit               tx_quiet = 1'b0;
    bit               rx_quiet = 1'b0;
    bit               hold_req = 1'b0;
    int               idle_cycles = 0;

    codepage_transcoder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_code_unit (i_code_unit),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_value     (o_value),
        .o_unmapped  (o_unmapped),
        .o_lossy     (o_lossy),
        .o_last_out  (o_last_out)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) begin
                sb.write_reg(i_cfg_index, i_cfg_data);
            end
            if (o_valid && !i_stall) begin
                sb.check_char(o_value, o_unmapped, o_lossy, o_last_out);
            end
            if (i_valid && !o_stall) begin
                sb.note_char(i_code_unit, i_last);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(20, 60);
    endfunction

    // Receiver: random stall runs, quiet stretches and one long hold-off on request.
    initial begin
        int  run_left;
        int  hold_left;
        int  r;
        bit  run_stall;
        run_left  = 0;
        hold_left = 0;
        run_stall = 1'b0;
        i_stall   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (rx_quiet) begin
                run_left = 0;
                i_stall <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    r = $urandom_range(0, 99);
                    if (r < 55) begin
                        run_stall = 1'b0;
                        run_left  = $urandom_range(1, 20);
                    end else begin
                        run_stall = 1'b1;
                        run_left  = pick_gap(1'b0);
                        if (run_left == 0) begin
                            run_left = 1;
                        end
                    end
                end
                run_left--;
                i_stall <= run_stall;
            end
        end
    end

    task automatic send_char(logic [CU_W-1:0] cu, logic last);
        int gap;
        gap = pick_gap(tx_quiet);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_code_unit <= cu;
        i_last      <= last;
        do begin
            @(posedge i_clk);
        end while (o_stall);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic set_mode(logic [PAGE_W-1:0] page, logic [CFG_DAT_W-1:0] dir_data);
        wait_idle();
        write_reg(REG_CODEPAGE, page);
        write_reg(REG_DIRECTION, dir_data);
    endtask

    function automatic logic [CU_W-1:0] pick_char(logic [PAGE_W-1:0] page, logic dir);
        int r;
        r = $urandom_range(0, 99);
        if (dir == DIR_DECODE) begin
            return {(r < 50) ? 8'h00 : 8'($urandom_range(0, 255)),
                    (r % 3 == 0) ? 8'($urandom_range(8'h80, 8'h9F))
                                 : 8'($urandom_range(0, 255))};
        end
        if (r < 30) begin
            return 16'($urandom_range(0, 255));
        end else if (r < 55) begin
            if (page == CP_1252) begin
                return T1252_C1[5'($urandom_range(0, 31))];
            end else if ($urandom_range(0, 3) == 0) begin
                return T1250_C1[5'($urandom_range(0, 31))];
            end
            return T1250_G1[7'($urandom_range(0, 95))];
        end else if (r < 60) begin
            return REPL_CHAR;
        end else if (r < 70) begin
            return 16'($urandom_range(16'h0080, 16'h009F));
        end
        return 16'($urandom());
    endfunction

    initial begin
        logic [PAGE_W-1:0] page;
        logic              dir;
        int                str_left;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_code_unit = '0;
        i_last      = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_mode(CP_LATIN1, {1'b0, DIR_ENCODE});
        send_char(16'h0000, 1'b0);
        send_char(16'h00FF, 1'b0);
        send_char(16'h0100, 1'b0);
        send_char(16'hFFFF, 1'b1);
        set_mode(CP_1252, {1'b0, DIR_ENCODE});
        send_char(16'h20AC, 1'b0);
        send_char(REPL_CHAR, 1'b0);
        send_char(16'h0085, 1'b0);
        send_char(16'h0178, 1'b0);
        send_char(16'h007F, 1'b1);
        set_mode(CP_1250, {1'b0, DIR_ENCODE});
        send_char(16'h02C7, 1'b0);
        send_char(16'h00A0, 1'b0);
        send_char(16'h02D9, 1'b0);
        send_char(16'h00FF, 1'b0);
        send_char(16'h0090, 1'b1);
        set_mode(CP_1252, {1'b1, DIR_DECODE});
        send_char(16'hAB81, 1'b0);
        send_char(16'h0080, 1'b0);
        send_char(16'h009F, 1'b1);
        set_mode(CP_1250, {1'b0, DIR_DECODE});
        send_char(16'h00FF, 1'b0);
        send_char(16'h00A1, 1'b0);
        send_char(16'hFF98, 1'b1);
        set_mode(CP_LATIN1, {1'b1, DIR_DECODE});
        send_char(16'hFF9D, 1'b1);
        set_mode(CP_UNUSED, {1'b1, DIR_ENCODE});
        send_char(16'h00E9, 1'b0);
        send_char(16'h1234, 1'b1);

        for (int p = 0; p < N_PHASES; p++) begin
            page = PAGE_W'(p % 4);
            dir  = ((p / 4) % 2 == 1) ? DIR_DECODE : DIR_ENCODE;
            set_mode(page, {1'($urandom_range(0, 1)), dir});
            tx_quiet = (p % 5 == 3);
            rx_quiet = (p % 5 == 3);
            if (p == 5) begin
                tx_quiet = 1'b1;
                hold_req = 1'b1;
            end
            str_left = $urandom_range(1, 12);
            for (int n = 0; n < PHASE_LEN; n++) begin
                send_char(pick_char(page, dir), str_left == 1);
                str_left--;
                if (str_left == 0) begin
                    str_left = $urandom_range(1, 12);
                end
            end
            tx_quiet = 1'b0;
            rx_quiet = 1'b0;
        end

        wait_idle();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end
endmodule

// File: files.f
+incdir+hdl
hdl/cpt_pkg.sv
hdl/codepage_transcoder.sv
test/tb_top.sv
